[sv/assert_macros.svh]
// Assertion helper macros shared by the heap queue RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// ante true at an edge -> cons true at the same edge
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// ante true at an edge -> cons true at the next edge
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
// expr must never hold
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif

`endif

[sv/bmhq_pkg.sv]
// Shared constants, types and helpers for the binary max-heap queue.
// Depends on nothing; used by bmhq_ctrl, bmhq_dp and the top level.
`timescale 1ns / 1ps

package bmhq_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = CNT_W + 1;   // child index, may run past the end
  localparam int KEY_W    = 32;
  localparam int STAT_W   = 2;
  localparam int OCNT_W   = 11;          // entry_count field width

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } bmhq_status_t;

  // controller -> datapath
  typedef struct packed {
    logic start;     // word accepted: latch key, set status, adjust count
    logic up_rd;     // sift up: read parent (or settle at root)
    logic up_cmp;    // sift up: compare parent, move it down or settle
    logic dn_last;   // delete: read last entry
    logic dn_load;   // delete: last entry becomes the moving key
    logic dn_rd;     // sift down: read both children (or settle)
    logic dn_cmp;    // sift down: pick child, move it up or settle
    logic emit;      // load the output register
  } bmhq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic reject;    // insert on full or delete on empty
    logic push;      // incoming word is an insert
    logic pos_zero;  // moving key sits at the root
    logic up_less;   // parent strictly smaller than moving key
    logic n_zero;    // heap empty after the delete
    logic no_left;   // no left child inside the heap
    logic pick_less; // moving key strictly smaller than chosen child
  } bmhq_stat_t;

  function automatic logic key_less(logic signed [KEY_W-1:0] a,
                                    logic signed [KEY_W-1:0] b);
    return a < b;
  endfunction

endpackage

[sv/bmhq_dp.sv]
// Datapath of the heap queue: key memory, position/key registers, result register.
// Depends on bmhq_pkg and assert_macros.svh; driven by bmhq_ctrl commands.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmhq_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_action,
  input  logic signed [bmhq_pkg::KEY_W-1:0]    in_value,
  input  bmhq_pkg::bmhq_cmd_t                  cmd,
  output bmhq_pkg::bmhq_stat_t                 stat,
  output bmhq_pkg::bmhq_status_t               out_status,
  output logic signed [bmhq_pkg::KEY_W-1:0]    out_top,
  output logic [bmhq_pkg::OCNT_W-1:0]          out_count
);

  localparam int AW = bmhq_pkg::ADDR_W;
  localparam int CW = bmhq_pkg::CNT_W;
  localparam int IW = bmhq_pkg::IDX_W;
  localparam int KW = bmhq_pkg::KEY_W;

  logic signed [KW-1:0]   key_mem [bmhq_pkg::CAPACITY];

  logic [CW-1:0]          count;
  logic [AW-1:0]          pos;
  logic signed [KW-1:0]   key;
  logic signed [KW-1:0]   top_key;
  logic signed [KW-1:0]   rd_a;
  logic signed [KW-1:0]   rd_b;
  logic                   right_ok;
  bmhq_pkg::bmhq_status_t status_r;

  logic [AW-1:0]          up_idx;
  logic [IW-1:0]          left;
  logic [IW-1:0]          right;
  logic [IW-1:0]          n_ext;
  logic                   pick_right;
  logic signed [KW-1:0]   pick_val;
  logic [AW-1:0]          pick_idx;
  logic [AW-1:0]          addr_a;
  logic [AW-1:0]          addr_b;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic signed [KW-1:0]   wr_data;

  // index arithmetic
  assign up_idx     = (pos - AW'(1)) >> 1;
  assign left       = IW'({pos, 1'b1});
  assign right      = left + IW'(1);
  assign n_ext      = IW'(count);
  assign pick_right = right_ok && bmhq_pkg::key_less(rd_a, rd_b);
  assign pick_val   = pick_right ? rd_b : rd_a;
  assign pick_idx   = pick_right ? right[AW-1:0] : left[AW-1:0];

  always_comb begin
    stat.reject    = (in_action == bmhq_pkg::ACT_POP) ? (count == '0)
                                                      : (count == CW'(bmhq_pkg::CAPACITY));
    stat.push      = (in_action == bmhq_pkg::ACT_PUSH);
    stat.pos_zero  = (pos == '0);
    stat.up_less   = bmhq_pkg::key_less(rd_a, key);
    stat.n_zero    = (count == '0);
    stat.no_left   = (left >= n_ext);
    stat.pick_less = bmhq_pkg::key_less(key, pick_val);
  end

  // read addresses: port A parent / last / left, port B right
  always_comb begin
    addr_a = '0;
    if (cmd.up_rd) begin
      addr_a = up_idx;
    end else if (cmd.dn_last) begin
      addr_a = count[AW-1:0];
    end else if (cmd.dn_rd) begin
      addr_a = left[AW-1:0];
    end
    addr_b = right[AW-1:0];
  end

  // single write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = key;
    if (cmd.up_rd && stat.pos_zero) begin
      wr_en = 1'b1;
    end else if (cmd.up_cmp) begin
      wr_en = 1'b1;
      if (stat.up_less) begin
        wr_data = rd_a;
      end
    end else if (cmd.dn_rd && stat.no_left) begin
      wr_en = 1'b1;
    end else if (cmd.dn_cmp) begin
      wr_en = 1'b1;
      if (stat.pick_less) begin
        wr_data = pick_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_data;
    end
    rd_a <= key_mem[addr_a];
    rd_b <= key_mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.start && !stat.reject) begin
      count <= stat.push ? count + CW'(1) : count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key      <= in_value;
      status_r <= !stat.reject ? bmhq_pkg::ST_OK
                : (stat.push ? bmhq_pkg::ST_FULL : bmhq_pkg::ST_EMPTY);
      pos      <= stat.push ? count[AW-1:0] : '0;
    end
    if (cmd.up_cmp && stat.up_less) begin
      pos <= up_idx;
    end
    if (cmd.dn_load) begin
      key <= rd_a;
    end
    if (cmd.dn_rd) begin
      right_ok <= (right < n_ext);
    end
    if (cmd.dn_cmp && stat.pick_less) begin
      pos <= pick_idx;
    end
    if (wr_en && wr_addr == '0) begin
      top_key <= wr_data;
    end
    if (cmd.emit) begin
      out_status <= status_r;
      out_top    <= (count != '0) ? top_key : '0;
      out_count  <= bmhq_pkg::OCNT_W'(count);
    end
  end

  `ASSERT_NEVER(a_count_in_range, clk, rst, count > CW'(bmhq_pkg::CAPACITY), "count past capacity")
  `ASSERT_IMPLY(a_write_in_heap, clk, rst, wr_en, CW'(wr_addr) < count, "write outside heap")
  `ASSERT_IMPLY(a_pick_in_heap, clk, rst, cmd.dn_cmp && stat.pick_less, CW'(pick_idx) < count, "child outside heap")

endmodule

[sv/bmhq_ctrl.sv]
// Controller of the heap queue: one-hot sequencer for insert/delete and output handshake.
// Depends on bmhq_pkg and assert_macros.svh; drives bmhq_dp.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmhq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  bmhq_pkg::bmhq_stat_t stat,
  output bmhq_pkg::bmhq_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_UP_RD   = 8'b0000_0010,
    S_UP_CMP  = 8'b0000_0100,
    S_DN_LAST = 8'b0000_1000,
    S_DN_LOAD = 8'b0001_0000,
    S_DN_RD   = 8'b0010_0000,
    S_DN_CMP  = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          if (stat.reject) begin
            state_next = S_DONE;
          end else if (stat.push) begin
            state_next = S_UP_RD;
          end else begin
            state_next = S_DN_LAST;
          end
        end
      end
      S_UP_RD: begin
        cmd.up_rd  = 1'b1;
        state_next = stat.pos_zero ? S_DONE : S_UP_CMP;
      end
      S_UP_CMP: begin
        cmd.up_cmp = 1'b1;
        state_next = stat.up_less ? S_UP_RD : S_DONE;
      end
      S_DN_LAST: begin
        cmd.dn_last = 1'b1;
        state_next  = stat.n_zero ? S_DONE : S_DN_LOAD;
      end
      S_DN_LOAD: begin
        cmd.dn_load = 1'b1;
        state_next  = S_DN_RD;
      end
      S_DN_RD: begin
        cmd.dn_rd  = 1'b1;
        state_next = stat.no_left ? S_DONE : S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd.dn_cmp = 1'b1;
        state_next = stat.pick_less ? S_DN_RD : S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ASSERT_NEVER(a_cmd_exclusive, clk, rst, !$onehot0(cmd), "overlapping datapath commands")
  `ASSERT_NEXT(a_start_busy, clk, rst, cmd.start, state != S_IDLE, "accept did not leave idle")
  `ASSERT_NEXT(a_done_holds, clk, rst, state == S_DONE && out_valid && !out_ready, state == S_DONE, "finished word dropped")

endmodule

[sv/binary_max_heap_queue.sv]
// Top level of the binary max-heap priority queue.
// Depends on bmhq_pkg, bmhq_ctrl and bmhq_dp.
`timescale 1ns / 1ps
//
// Channel  | Dir | Handshake          | Payload
// ---------+-----+--------------------+---------------------------------------
// s_*      | in  | s_tvalid/s_tready  | tuser: action; tdata: value
// m_*      | out | m_tvalid/m_tready  | tuser: status; tdata: top_value, count
//
// After accept, an insert runs S_UP_RD and S_UP_CMP per level climbed, a delete
// runs S_DN_LAST, S_DN_LOAD, then S_DN_RD and S_DN_CMP per level descended;
// a delete to empty stops after S_DN_LAST, a reject goes straight to S_DONE.
// Each level is one registered read (parent or both children) and one write.
// rst is synchronous; it empties the heap and drops any pending result.
// A finished result waits in S_DONE only while the output register is full.

module binary_max_heap_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tuser,   // [0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [31:0] top_value, [42:32] entry_count, rest zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  bmhq_pkg::bmhq_cmd_t                 cmd;
  bmhq_pkg::bmhq_stat_t                stat;
  bmhq_pkg::bmhq_status_t              out_status;
  logic signed [bmhq_pkg::KEY_W-1:0]   out_top;
  logic [bmhq_pkg::OCNT_W-1:0]         out_count;

  bmhq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bmhq_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_action  (s_tuser),
    .in_value   (s_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_status (out_status),
    .out_top    (out_top),
    .out_count  (out_count)
  );

  // word layout: top_value low, entry_count above, zero fill to 48 bits
  assign m_tdata = {5'b0, out_count, out_top};
  assign m_tuser = out_status;

endmodule

[bench/tb_top.sv]
// Self-checking bench for binary_max_heap_queue: directed and random insert/delete words.
// Depends on bmhq_pkg and binary_max_heap_queue; results are checked against a heap model.
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_GAP     = 12;
  localparam int HOLD_CYCLES = 400;   // long receiver stall
  localparam int IDLE_LIMIT  = 2000;  // cycles with no word moving on either side
  localparam int TAIL_CYCLES = 40;    // quiet time after the last result

  localparam logic [bmhq_pkg::KEY_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam logic [bmhq_pkg::KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;

  typedef struct packed {
    bmhq_pkg::bmhq_status_t             status;
    logic signed [bmhq_pkg::KEY_W-1:0]  top;
    logic [bmhq_pkg::OCNT_W-1:0]        count;
  } heap_result_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [bmhq_pkg::KEY_W-1:0]  s_tdata = '0;   // [31:0] value
  logic                        s_tuser = 1'b0; // [0] action
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [47:0]                 m_tdata;        // [31:0] top_value, [42:32] entry_count
  logic [1:0]                  m_tuser;        // [1:0] status

  // Heap model state, updated at each accepted input word.
  logic signed [bmhq_pkg::KEY_W-1:0] heap_keys [bmhq_pkg::CAPACITY];
  int                                heap_size = 0;

  heap_result_t pending_results [$];
  int           mismatch_count = 0;

  // Pacing controls shared between sender and receiver.
  bit tx_burst = 1'b0;  // sender offers back to back
  bit rx_burst = 1'b0;  // receiver never idles
  bit hold_req = 1'b0;  // receiver takes one long stall

  always #4 clk = ~clk;

  binary_max_heap_queue u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Apply one word to the heap model and return the result it should produce.
  // Sift-up and sift-down move a key only when it is strictly smaller;
  // on equal children the left one is chosen, and a lone left child counts.
  function automatic heap_result_t predict_heap_op(
      input logic act,
      input logic signed [bmhq_pkg::KEY_W-1:0] val);
    heap_result_t                      r;
    logic signed [bmhq_pkg::KEY_W-1:0] tmp;
    int                                pos;
    int                                up;
    int                                left;
    int                                pick;
    int                                n;
    r.status = bmhq_pkg::ST_OK;
    if (act == bmhq_pkg::ACT_PUSH) begin
      if (heap_size >= bmhq_pkg::CAPACITY) begin
        r.status = bmhq_pkg::ST_FULL;
      end else begin
        pos = heap_size;
        heap_keys[pos] = val;
        heap_size++;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (!(heap_keys[up] < heap_keys[pos])) break;
          tmp = heap_keys[up];
          heap_keys[up] = heap_keys[pos];
          heap_keys[pos] = tmp;
          pos = up;
        end
      end
    end else begin
      if (heap_size == 0) begin
        r.status = bmhq_pkg::ST_EMPTY;
      end else begin
        n = heap_size - 1;
        heap_keys[0] = heap_keys[n];
        heap_size = n;
        pos = 0;
        forever begin
          left = 2 * pos + 1;
          if (left >= n) break;
          pick = left;
          if (left + 1 < n && heap_keys[left] < heap_keys[left + 1]) pick = left + 1;
          if (!(heap_keys[pos] < heap_keys[pick])) break;
          tmp = heap_keys[pos];
          heap_keys[pos] = heap_keys[pick];
          heap_keys[pick] = tmp;
          pos = pick;
        end
      end
    end
    r.top   = (heap_size > 0) ? heap_keys[0] : '0;
    r.count = heap_size[bmhq_pkg::OCNT_W-1:0];
    return r;
  endfunction

  // Append one expected result to the in-order scoreboard.
  function automatic void note_expected(input heap_result_t r);
    pending_results = {pending_results, r};
  endfunction

  // Key mix: extremes, a narrow band for duplicates, and full-range values.
  function automatic logic [bmhq_pkg::KEY_W-1:0] rand_key();
    case ($urandom_range(0, 9))
      0:       return KEY_MIN;
      1:       return KEY_MAX;
      2:       return $urandom_range(0, 8) - 4;
      3, 4:    return $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  // Offer one word after a random gap (none while tx_burst); predict its result once it is taken.
  // valid stays high when the next word follows with no gap.
  task automatic send_word(input logic act, input logic [bmhq_pkg::KEY_W-1:0] val);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= val;
    do @(posedge clk); while (!s_tready);
    note_expected(predict_heap_op(act, val));
  endtask

  // Sender pause: drop valid and hold until every result is back.
  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Delete on empty, then the same after one insert/delete pair.
  task automatic test_empty_heap();
    send_word(bmhq_pkg::ACT_POP, $urandom());
    send_word(bmhq_pkg::ACT_PUSH, KEY_MIN);
    send_word(bmhq_pkg::ACT_POP, $urandom());
    send_word(bmhq_pkg::ACT_POP, $urandom());
    wait_results_drained();
  endtask

  // Signed order at the ends of the key range.
  task automatic test_extreme_keys();
    send_word(bmhq_pkg::ACT_PUSH, KEY_MIN);
    send_word(bmhq_pkg::ACT_PUSH, KEY_MAX);
    send_word(bmhq_pkg::ACT_PUSH, 32'h0);
    send_word(bmhq_pkg::ACT_PUSH, 32'hffff_ffff);
    repeat (4) send_word(bmhq_pkg::ACT_POP, $urandom());
    wait_results_drained();
  endtask

  // After the first delete the root has only a left child and must move.
  task automatic test_lone_left_child();
    send_word(bmhq_pkg::ACT_PUSH, 32'd10);
    send_word(bmhq_pkg::ACT_PUSH, 32'd8);
    send_word(bmhq_pkg::ACT_PUSH, 32'd1);
    repeat (3) send_word(bmhq_pkg::ACT_POP, $urandom());
    wait_results_drained();
  endtask

  // Equal children on sift-down.
  task automatic test_equal_children();
    send_word(bmhq_pkg::ACT_PUSH, 32'd10);
    send_word(bmhq_pkg::ACT_PUSH, 32'd7);
    send_word(bmhq_pkg::ACT_PUSH, 32'd7);
    send_word(bmhq_pkg::ACT_PUSH, 32'd1);
    repeat (4) send_word(bmhq_pkg::ACT_POP, $urandom());
    wait_results_drained();
  endtask

  // Balanced mix near empty; opens with a back-to-back stretch.
  task automatic test_random_mix();
    tx_burst = 1'b1;
    rx_burst = 1'b1;
    for (int i = 0; i < 100; i++) begin
      if (i == 30) begin
        tx_burst = 1'b0;
        rx_burst = 1'b0;
      end
      send_word($urandom_range(0, 1) ? bmhq_pkg::ACT_POP : bmhq_pkg::ACT_PUSH, rand_key());
    end
    wait_results_drained();
  endtask

  // Receiver stalls for a long time while words keep coming, so s_tready drops.
  task automatic test_output_stall();
    hold_req = 1'b1;
    tx_burst = 1'b1;
    repeat (20) send_word(($urandom_range(0, 3) == 0) ? bmhq_pkg::ACT_POP
                                                       : bmhq_pkg::ACT_PUSH, rand_key());
    tx_burst = 1'b0;
    wait_results_drained();
  endtask

  // Insert-heavy until several inserts have bounced off a full heap.
  task automatic test_fill_to_full();
    int full_rejects;
    int n;
    full_rejects = 0;
    n = 0;
    while (full_rejects < 8) begin
      if (n % 100 == 0) begin
        tx_burst = ($urandom_range(0, 3) == 0);
        rx_burst = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 99) < 92) begin
        if (heap_size == bmhq_pkg::CAPACITY) full_rejects++;
        send_word(bmhq_pkg::ACT_PUSH, rand_key());
      end else begin
        send_word(bmhq_pkg::ACT_POP, $urandom());
      end
      n++;
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    wait_results_drained();
  endtask

  // Delete-heavy run from the full heap.
  task automatic test_drain();
    repeat (100) send_word(($urandom_range(0, 99) < 85) ? bmhq_pkg::ACT_POP
                                                         : bmhq_pkg::ACT_PUSH, rand_key());
    wait_results_drained();
  endtask

  // Receiver: random ready gaps, one long hold on request, in-order checking.
  initial begin
    int           gap;
    heap_result_t want;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: result with nothing pending: status %0d top %0d count %0d",
                   $realtime, m_tuser, $signed(m_tdata[31:0]), m_tdata[42:32]);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.status || m_tdata[31:0] !== want.top ||
            m_tdata[42:32] !== want.count) begin
          if (mismatch_count < 10)
            $display("%0t: mismatch: expected status %0d top %0d count %0d, got %0d %0d %0d",
                     $realtime, want.status, want.top, want.count,
                     m_tuser, $signed(m_tdata[31:0]), m_tdata[42:32]);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: too long with no word moving on either side ends the run.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("** binary_max_heap_queue: FAILED **");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_empty_heap();
    test_extreme_keys();
    test_lone_left_child();
    test_equal_children();
    test_random_mix();
    test_output_stall();
    test_fill_to_full();
    test_drain();
    // stray results would show up here
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("** binary_max_heap_queue: PASSED **");
    end else begin
      $display("** binary_max_heap_queue: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/bmhq_pkg.sv
sv/bmhq_dp.sv
sv/bmhq_ctrl.sv
sv/binary_max_heap_queue.sv
bench/tb_top.sv
